// File: rtl/fwc_pkg.sv
// ----------------------------------------------------------------------------
// fwc_pkg: shared types and constants of the window cache
// Payload structs, register indexes, status codes and widths.
// ----------------------------------------------------------------------------
package fwc_pkg;

  localparam int unsigned MaxWindows = 16;
  localparam int unsigned SlotW      = 4;
  localparam int unsigned CountW     = 5;
  localparam int unsigned AddrW      = 40;
  localparam int unsigned ChunkW     = 31;
  localparam int unsigned LenW       = 32;
  localparam int unsigned UsesW      = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 40;

  localparam logic [CfgIdxW-1:0] RegChunkSize  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxWindows = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFileLength = 2'd2;

  localparam logic [1:0] StHit      = 2'd0;
  localparam logic [1:0] StMiss     = 2'd1;
  localparam logic [1:0] StMissEvict = 2'd2;
  localparam logic [1:0] StError    = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0]  access_offset;
    logic [ChunkW-1:0] access_size;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SlotW-1:0]  slot;
    logic [AddrW-1:0]  window_base;
    logic [LenW-1:0]   window_length;
    logic [ChunkW-1:0] offset_in_window;
    logic [AddrW-1:0]  victim_base;
    logic [LenW-1:0]   victim_length;
    logic [CountW-1:0] windows_in_use;
  } rsp_t;

endpackage

// File: rtl/file_window_cache_lfu_unit.sv
// ----------------------------------------------------------------------------
// file_window_cache_lfu_unit: LFU replaced mapping window cache
// Finds a window covering an access, maps a new chunk aligned one on a miss.
// ----------------------------------------------------------------------------
// channel | dir | handshake            | payload
// req     | in  | req_valid/req_ready  | req_i (offset, size)
// rsp     | out | rsp_valid/rsp_ready  | rsp_o (status .. windows_in_use)
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index_i, cfg_data_i
//
// An access passes an accept state and a check state, then scans the entries,
// reading and then comparing each one, and leaves the scan. A hit waits for
// the read and bumps the use count; a miss on a full table makes a second pass
// over the entries for the least used one and moves the last entry into its
// slot; a miss then runs a restoring division and one append. Each access ends
// with the result state; an error goes from the check straight to it. Entry
// tables sit in a one port synchronous memory; the scan alternates a read state
// and a compare state.
// Reset empties the table at once. A held result blocks the next access only
// once the next one is finished too.
// ----------------------------------------------------------------------------
module file_window_cache_lfu_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  fwc_pkg::req_t                req_i,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output fwc_pkg::rsp_t                rsp_o,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fwc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [fwc_pkg::CfgDataW-1:0] cfg_data_i
);
  import fwc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_SCAN_WAIT, S_MIN, S_MIN_WAIT, S_LAST_WAIT,
    S_MOVE, S_DIV, S_APPEND, S_BUMP_WAIT, S_BUMP, S_DONE
  } state_e;

  localparam int unsigned EntW = AddrW + LenW + UsesW;

  state_e state_q;

  logic [ChunkW-1:0] chunk_q;
  logic [CountW-1:0] maxw_q;
  logic [AddrW-1:0]  flen_q;
  logic [CountW-1:0] count_q;

  logic [EntW-1:0] mem [MaxWindows];
  logic [EntW-1:0] rdata_q;
  logic [SlotW-1:0] raddr;
  logic             rd_en;
  logic [SlotW-1:0] waddr;
  logic [EntW-1:0]  wdata;
  logic             wr_en;

  logic [AddrW-1:0]  off_q;
  logic [ChunkW-1:0] size_q;
  logic [CountW-1:0] idx_q;
  logic [SlotW-1:0]  rd_idx_q;
  logic [SlotW-1:0]  vic_q;
  logic [UsesW-1:0]  vic_uses_q;
  logic [AddrW-1:0]  vbase_q;
  logic [LenW-1:0]   vlen_q;
  logic              evict_q;
  logic [SlotW-1:0]  slot_q;
  logic [AddrW-1:0]  rem_q;
  logic [AddrW-1:0]  quo_q;
  logic [5:0]        dcnt_q;
  logic [AddrW-1:0]  base_q;
  logic [LenW-1:0]   new_len;
  logic              rsp_valid_q;
  rsp_t              res_q;
  rsp_t              rsp_q;

  // entry fields of the registered read
  logic [AddrW-1:0] r_base;
  logic [LenW-1:0]  r_len;
  logic [UsesW-1:0] r_uses;
  assign r_base = rdata_q[EntW-1 -: AddrW];
  assign r_len  = rdata_q[UsesW +: LenW];
  assign r_uses = rdata_q[UsesW-1:0];

  logic [AddrW:0] end_acc;
  logic [AddrW:0] end_win;
  logic           covers;
  assign end_acc = {1'b0, off_q} + {{(AddrW-ChunkW+1){1'b0}}, size_q};
  assign end_win = {1'b0, r_base} + {{(AddrW-LenW+1){1'b0}}, r_len};
  assign covers  = (off_q >= r_base) && (end_acc <= end_win);

  logic [CountW-1:0] limit;
  always_comb begin
    limit = maxw_q;
    if (maxw_q == '0) limit = CountW'(1);
    if (maxw_q > CountW'(MaxWindows)) limit = CountW'(MaxWindows);
  end

  logic bad;
  assign bad = (chunk_q == '0) || (size_q > chunk_q) || (end_acc > {1'b0, flen_q});

  // restoring division step
  logic [AddrW:0] rem_sh;
  logic           sub_ok;
  assign rem_sh = {rem_q, quo_q[AddrW-1]};
  assign sub_ok = rem_sh >= {{(AddrW-ChunkW+1){1'b0}}, chunk_q};

  logic [AddrW:0] span;
  assign span = {1'b0, off_q - base_q} + {{(AddrW-ChunkW+1){1'b0}}, size_q};

  logic [SlotW-1:0] last_slot;
  assign last_slot = SlotW'(count_q - CountW'(1));

  assign req_ready = (state_q == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_q == S_IDLE);
  assign rsp_valid = rsp_valid_q;
  assign rsp_o     = rsp_q;

  // memory read/write control
  always_comb begin
    rd_en = 1'b0;
    raddr = idx_q[SlotW-1:0];
    wr_en = 1'b0;
    waddr = slot_q;
    wdata = '0;
    case (state_q)
      S_SCAN, S_MIN: rd_en = 1'b1;
      S_MOVE: begin
        if (vic_q != last_slot) begin
          wr_en = 1'b1;
          waddr = vic_q;
          wdata = rdata_q;
        end
      end
      S_APPEND: begin
        wr_en = 1'b1;
        waddr = slot_q;
        wdata = {base_q, new_len, UsesW'(1)};
      end
      S_BUMP: begin
        if (r_uses != '1) begin
          wr_en = 1'b1;
          waddr = slot_q;
          wdata = {r_base, r_len, r_uses + UsesW'(1)};
        end
      end
      default: ;
    endcase
    if (state_q == S_MIN && idx_q == count_q) raddr = last_slot;
    if (state_q == S_DONE) raddr = slot_q;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[waddr] <= wdata;
    if (rd_en || state_q == S_DONE) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chunk_q     <= ChunkW'(65536);
      maxw_q      <= CountW'(16);
      flen_q      <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!rsp_valid_q || rsp_ready)) rsp_valid_q <= 1'b1;
      else if (rsp_valid_q && rsp_ready) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index_i)
              RegChunkSize:  chunk_q <= cfg_data_i[ChunkW-1:0];
              RegMaxWindows: maxw_q  <= cfg_data_i[CountW-1:0];
              RegFileLength: flen_q  <= cfg_data_i[AddrW-1:0];
              default: ;
            endcase
          end
          if (req_valid && req_ready) begin
            off_q   <= req_i.access_offset;
            size_q  <= req_i.access_size;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          evict_q <= 1'b0;
          vbase_q <= '0;
          vlen_q  <= '0;
          idx_q   <= '0;
          if (bad) begin
            res_q <= '{status: StError, windows_in_use: count_q, default: '0};
            state_q <= S_DONE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue read of entry idx, or leave on a full miss
          if (idx_q == count_q) begin
            idx_q <= '0;
            if (count_q >= limit && count_q != '0) begin
              evict_q <= 1'b1;
              state_q <= S_MIN;
            end else begin
              state_q <= S_DIV;
              rem_q   <= '0;
              quo_q   <= off_q;
              dcnt_q  <= '0;
            end
          end else begin
            rd_idx_q <= idx_q[SlotW-1:0];
            idx_q    <= idx_q + CountW'(1);
            state_q  <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: begin
          if (covers) begin
            slot_q  <= rd_idx_q;
            state_q <= S_BUMP_WAIT;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_MIN: begin
          rd_idx_q <= idx_q[SlotW-1:0];
          if (idx_q == count_q) begin
            state_q <= S_LAST_WAIT;
          end else begin
            idx_q   <= idx_q + CountW'(1);
            state_q <= S_MIN_WAIT;
          end
        end
        S_MIN_WAIT: begin
          if (rd_idx_q == '0 || r_uses < vic_uses_q) begin
            vic_q      <= rd_idx_q;
            vic_uses_q <= r_uses;
            vbase_q    <= r_base;
            vlen_q     <= r_len;
          end
          state_q <= S_MIN;
        end
        S_LAST_WAIT: state_q <= S_MOVE;
        S_MOVE: begin
          // last entry fills the victim slot
          count_q <= count_q - CountW'(1);
          rem_q   <= '0;
          quo_q   <= off_q;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dcnt_q == 6'(AddrW)) begin
            // quotient done; base = off - remainder
            base_q  <= off_q - rem_q;
            state_q <= S_APPEND;
          end else begin
            rem_q  <= sub_ok ? (rem_sh[AddrW-1:0] - AddrW'(chunk_q)) : rem_sh[AddrW-1:0];
            quo_q  <= {quo_q[AddrW-2:0], sub_ok};
            dcnt_q <= dcnt_q + 6'd1;
          end
          slot_q <= SlotW'(count_q);
        end
        S_APPEND: begin
          count_q <= count_q + CountW'(1);
          res_q.status <= evict_q ? StMissEvict : StMiss;
          res_q.slot <= slot_q;
          res_q.window_base <= base_q;
          res_q.window_length <= new_len;
          res_q.offset_in_window <= ChunkW'(off_q - base_q);
          res_q.victim_base <= vbase_q;
          res_q.victim_length <= vlen_q;
          res_q.windows_in_use <= count_q + CountW'(1);
          state_q <= S_DONE;
        end
        S_BUMP_WAIT: state_q <= S_BUMP;
        S_BUMP: begin
          res_q.status <= StHit;
          res_q.slot <= slot_q;
          res_q.window_base <= r_base;
          res_q.window_length <= r_len;
          res_q.offset_in_window <= ChunkW'(off_q - r_base);
          res_q.victim_base <= '0;
          res_q.victim_length <= '0;
          res_q.windows_in_use <= count_q;
          state_q <= S_DONE;
        end
        S_DONE: begin
          // hand the beat to the output register once it is free
          if (!rsp_valid_q || rsp_ready) begin
            rsp_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // window length follows the crossing test on the fresh base
  always_comb begin
    new_len = {1'b0, chunk_q};
    if (span > {{(AddrW-ChunkW+1){1'b0}}, chunk_q}) new_len = {chunk_q, 1'b0};
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxWindows)) else $error("entry count above table size");
  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en)) else $error("memory read and write in one cycle");
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOVE |-> count_q != '0) else $error("eviction from empty table");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !rsp_ready |=> rsp_valid_q && $stable(rsp_q))
    else $error("result changed while stalled");

endmodule

// File: bench/tb_file_window_cache_lfu_unit.sv
// ----------------------------------------------------------------------------
// Window cache testbench
// Drives accesses and register writes through valid/ready channels, predicts
// every response with an in-bench model of the LFU window table, and compares
// each response in full. Random gaps on both sides, one long stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_file_window_cache_lfu_unit;
  import fwc_pkg::*;

  logic clk_i, rst_ni;
  logic req_valid, req_ready, rsp_valid, rsp_ready, cfg_valid, cfg_ready;
  req_t req_i;
  rsp_t rsp_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  file_window_cache_lfu_unit DUT (.*);

  // predictor state
  logic [63:0] chunk_q, limit_q, flen_q;
  logic [63:0] win_base [MaxWindows];
  logic [63:0] win_len  [MaxWindows];
  logic [63:0] win_uses [MaxWindows];
  int unsigned win_cnt;

  rsp_t expected_rsps[$];
  int errors, accesses, responses, evictions, fault_cnt;
  int idle_cycles;
  bit hold_req;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic rsp_t predict_access(logic [39:0] off40, logic [30:0] sz31);
    rsp_t r;
    logic [63:0] off, size, base, len;
    int unsigned slot, v, lim;
    bit found;
    off = 64'(off40); size = 64'(sz31); r = '0; found = 0; slot = 0;
    if (chunk_q == 0 || size > chunk_q || off + size > flen_q) begin
      r.status = StError;
      r.windows_in_use = CountW'(win_cnt);
      return r;
    end
    for (int i = 0; i < win_cnt; i++)
      if (!found && off >= win_base[i] && off + size <= win_base[i] + win_len[i]) begin
        slot = i; found = 1;
      end
    if (found) r.status = StHit;
    else begin
      r.status = StMiss;
      lim = (limit_q == 0) ? 1 : ((limit_q > MaxWindows) ? MaxWindows : 32'(limit_q));
      if (win_cnt >= lim && win_cnt > 0) begin
        v = 0;
        for (int i = 1; i < win_cnt; i++) if (win_uses[i] < win_uses[v]) v = i;
        r.victim_base = AddrW'(win_base[v]);
        r.victim_length = LenW'(win_len[v]);
        win_base[v] = win_base[win_cnt-1];
        win_len[v] = win_len[win_cnt-1];
        win_uses[v] = win_uses[win_cnt-1];
        win_cnt--;
        r.status = StMissEvict;
      end
      base = (off / chunk_q) * chunk_q;
      len = (off - base + size > chunk_q) ? chunk_q * 2 : chunk_q;
      slot = win_cnt;
      win_base[slot] = base & 64'hFF_FFFF_FFFF;
      win_len[slot] = len & 64'hFFFF_FFFF;
      win_uses[slot] = 0;
      win_cnt++;
    end
    if (win_uses[slot] < 64'hFFFF_FFFF) win_uses[slot]++;
    r.slot = SlotW'(slot);
    r.window_base = AddrW'(win_base[slot]);
    r.window_length = LenW'(win_len[slot]);
    r.offset_in_window = ChunkW'(off - win_base[slot]);
    r.windows_in_use = CountW'(win_cnt);
    return r;
  endfunction

  task automatic send_access(logic [39:0] off, logic [30:0] sz, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17));
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    req_i <= '{access_offset: off, access_size: sz};
    req_valid <= 1;
    do @(posedge clk_i); while (!req_ready);
    expected_rsps.insert(expected_rsps.size(), predict_access(off, sz));
    accesses++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    req_valid <= 0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val[39:0];
    cfg_valid <= 1;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      RegChunkSize:  chunk_q = val & 64'h7FFF_FFFF;
      RegMaxWindows: limit_q = val & 64'h1F;
      default:       flen_q = val & 64'hFF_FFFF_FFFF;
    endcase
    @(negedge clk_i);
  endtask

  task automatic setup(logic [63:0] chunk, logic [63:0] lim, logic [63:0] flen);
    wait_idle();
    write_reg(RegChunkSize, chunk);
    write_reg(RegMaxWindows, lim);
    write_reg(RegFileLength, flen);
    cfg_valid <= 0;
  endtask

  // response checker with random back-pressure
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_valid && rsp_ready) begin
      responses++;
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected response got %p", $time, rsp_o);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp_o !== e) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, rsp_o);
          errors++;
        end
        if (e.status == StMissEvict) evictions++;
        if (e.status == StError) fault_cnt++;
      end
    end
  end

  initial begin
    int wait_n;
    rsp_ready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // hold off for a long stretch so the block fills up
        hold_req = 0;
        rsp_ready <= 0;
        repeat (400) @(negedge clk_i);
      end else if (rsp_valid && !rsp_ready) begin
        wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
        repeat (wait_n) @(negedge clk_i);
        rsp_ready <= 1;
      end else rsp_ready <= 1'b1 & ($urandom_range(0, 3) != 0);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    setup(65536, 16, 1 << 20);
    send_access(0, 0);
    send_access(100, 16);
    send_access(65530, 100);          // crosses chunk end: double window
    send_access(0, 65536);            // size equal to chunk
    send_access(0, 65537);            // too large
    send_access((1 << 20) - 1, 2);    // past end of file
    send_access((1 << 20) - 1, 1);
    setup(1, 16, 64'hFF_FFFF_FFFF);   // smallest chunk
    send_access(40'hFF_FFFF_FFFE, 1);
    send_access(40'hFF_FFFF_FFFF, 1); // reaches past 40-bit file length
    send_access(5, 1);
    setup(1 << 30, 0, 64'hFF_FFFF_FFFF);  // limit 0 acts as 1
    send_access(40'h7F_FFFF_FFFF, 31'h4000_0000);
    send_access(0, 31'h4000_0000);
    send_access(40'hFF_0000_0000, 3);
    setup(0, 31, 1000);               // zero chunk: all errors
    send_access(0, 0);
    setup(64'h7FFF_FFFF, 31, 64'hFF_FFFF_FFFF); // largest chunk, limit clamps
    send_access(40'hFF_FFFF_0000, 31'h7FFF_FFFF);
    send_access(40'h80_0000_0000, 31'h7FFF_FFFF);
  endtask

  task automatic test_limit_lowered();
    setup(4096, 16, 1 << 24);
    for (int i = 0; i < 10; i++) send_access(40'(i * 4096), 8);
    setup(4096, 3, 1 << 24);          // count above new limit
    for (int i = 0; i < 6; i++) send_access(40'(100000 + i * 4096), 8);
  endtask

  task automatic test_random(int n, logic [63:0] chunk, logic [63:0] lim, logic [63:0] flen);
    logic [63:0] off, sz;
    setup(chunk, lim, flen);
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          off = {$urandom, $urandom} & 64'hFF_FFFF_FFFF;
          sz = 64'($urandom & 32'h7FFF_FFFF);
        end
        1: begin off = flen - $urandom_range(0, 40); sz = 64'($urandom_range(0, 80)); end
        default: begin
          off = $urandom_range(0, 11) * chunk + $urandom_range(0, 255) * (chunk >> 8);
          sz = (chunk >> $urandom_range(0, 12)) + $urandom_range(0, 3) - 1;
        end
      endcase
      send_access(off[39:0], sz[30:0]);
    end
  endtask

  task automatic test_backpressure();
    setup(256, 4, 1 << 16);
    hold_req = 1;
    repeat (30) send_access(40'($urandom_range(0, 60000)), 31'($urandom_range(0, 256)), 1);
  endtask

  initial begin
    errors = 0; accesses = 0; responses = 0; evictions = 0; fault_cnt = 0;
    idle_cycles = 0; hold_req = 0;
    req_valid = 0; req_i = '0; cfg_valid = 0; cfg_index_i = RegChunkSize; cfg_data_i = '0;
    chunk_q = 65536; limit_q = 16; flen_q = 0; win_cnt = 0;
    for (int i = 0; i < MaxWindows; i++) begin
      win_base[i] = 0; win_len[i] = 0; win_uses[i] = 0;
    end
    rst_ni = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    send_access(0, 0);                // reset file length 0: a zero-size access at 0 still misses and maps
    test_directed();
    test_limit_lowered();
    test_backpressure();
    test_random(300, 4096, 16, 1 << 20);
    test_random(250, 65536, 5, 1 << 22);
    test_random(150, 1, 2, 4096);
    test_random(100, 1 << 30, 16, 64'hFF_FFFF_FFFF);
    wait_idle();
    $display("Covered %0d accesses, %0d responses: %0d evictions, %0d errors flagged.",
             accesses, responses, evictions, fault_cnt);
    if (errors == 0 && expected_rsps.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
